/* hw/rtl/trdt_pkg.sv */
// shared constants and conversion functions for the temperature text block
`timescale 1ns / 1ps
`default_nettype none

package trdt_pkg;

	// field widths
	localparam int unsigned RawW   = 16;
	localparam int unsigned TimeW  = 7;
	localparam int unsigned WholeW = 7;
	localparam int unsigned CharW  = 6;

	// ascii codes, cut to the six-bit character field
	localparam logic [CharW-1:0] CH_SPACE = 6'd32;
	localparam logic [CharW-1:0] CH_MINUS = 6'd45;
	localparam logic [CharW-1:0] CH_ZERO  = 6'd48;
	localparam logic [CharW-1:0] CH_COLON = 6'd58;

	// sign detect mask on the high byte
	localparam logic [7:0] SIGN_MASK = 8'hF8;

	// threshold for a shown hundreds digit
	localparam logic [WholeW-1:0] HUNDRED = 7'd100;

	// quotient and remainder of a division by ten
	typedef struct packed {
		logic [3:0] quo;
		logic [3:0] rem;
	} digit_pair_t;

	// divide a seven-bit value by ten: multiply by 205, keep bits 14..11
	function automatic digit_pair_t div10(input logic [6:0] v);
		logic [17:0]  prod;
		logic [6:0]   back;
		digit_pair_t  res;
		prod     = {11'd0, v} * 18'd205;
		res.quo  = prod[14:11];
		back     = {3'd0, res.quo} * 7'd10;
		res.rem  = 4'(v - back);
		return res;
	endfunction

	// sixteenths to tenths digit
	function automatic logic [3:0] tenths_digit(input logic [3:0] sixteenths);
		logic [3:0] d;
		unique case (sixteenths)
			4'd0:  d = 4'd0;
			4'd1:  d = 4'd1;
			4'd2:  d = 4'd1;
			4'd3:  d = 4'd2;
			4'd4:  d = 4'd3;
			4'd5:  d = 4'd3;
			4'd6:  d = 4'd4;
			4'd7:  d = 4'd4;
			4'd8:  d = 4'd5;
			4'd9:  d = 4'd6;
			4'd10: d = 4'd6;
			4'd11: d = 4'd7;
			4'd12: d = 4'd8;
			4'd13: d = 4'd8;
			4'd14: d = 4'd9;
			4'd15: d = 4'd9;
			default: d = 4'd0;
		endcase
		return d;
	endfunction

	// digit to ascii character
	function automatic logic [CharW-1:0] to_char(input logic [3:0] d);
		return CH_ZERO + {2'd0, d};
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/temperature_reading_to_decimal_text.sv */
// top level: sensor temperature word and countdown time to display characters
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------
//  in      | in_valid, in_stall | raw_reading, minutes_left, seconds_left
//  out     | out_valid, out_stall | whole_degrees, is_negative, nine chars
//
// one item per cycle sustained while the output is not stalled; an item's result
// passes from its acceptance through the input register and the result register.
// the input register frees itself into the result register whenever that
// one is empty or being taken; while a result waits, an item is accepted into an empty input register.
// arst_n clears both valid flags only; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module temperature_reading_to_decimal_text (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [trdt_pkg::RawW-1:0]         raw_reading,
	input  wire logic [trdt_pkg::TimeW-1:0]        minutes_left,
	input  wire logic [trdt_pkg::TimeW-1:0]        seconds_left,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [trdt_pkg::WholeW-1:0]            whole_degrees,
	output logic                                   is_negative,
	output logic [trdt_pkg::CharW-1:0]             prefix_char,
	output logic [trdt_pkg::CharW-1:0]             hundreds_char,
	output logic [trdt_pkg::CharW-1:0]             tens_char,
	output logic [trdt_pkg::CharW-1:0]             ones_char,
	output logic [trdt_pkg::CharW-1:0]             tenths_char,
	output logic [trdt_pkg::CharW-1:0]             minute_tens_char,
	output logic [trdt_pkg::CharW-1:0]             minute_ones_char,
	output logic [trdt_pkg::CharW-1:0]             second_tens_char,
	output logic [trdt_pkg::CharW-1:0]             second_ones_char
);

	// input stage
	logic                             valid_s1;
	logic [trdt_pkg::RawW-1:0]        raw_s1;
	logic [trdt_pkg::TimeW-1:0]       mins_s1;
	logic [trdt_pkg::TimeW-1:0]       secs_s1;

	// result stage
	logic                             valid_s2;
	logic [trdt_pkg::WholeW-1:0]      whole_s2;
	logic                             neg_s2;
	logic [trdt_pkg::CharW-1:0]       prefix_s2;
	logic [trdt_pkg::CharW-1:0]       hund_s2;
	logic [trdt_pkg::CharW-1:0]       tens_s2;
	logic [trdt_pkg::CharW-1:0]       ones_s2;
	logic [trdt_pkg::CharW-1:0]       tenths_s2;
	logic [trdt_pkg::CharW-1:0]       mt_s2;
	logic [trdt_pkg::CharW-1:0]       mo_s2;
	logic [trdt_pkg::CharW-1:0]       st_s2;
	logic [trdt_pkg::CharW-1:0]       so_s2;

	// conversion logic
	logic                             neg;
	logic [trdt_pkg::RawW-1:0]        mag;
	logic [trdt_pkg::WholeW-1:0]      whole;
	logic                             hund_on;
	logic [trdt_pkg::WholeW-1:0]      below_hund;
	trdt_pkg::digit_pair_t            deg_dig;
	trdt_pkg::digit_pair_t            min_dig;
	trdt_pkg::digit_pair_t            sec_dig;
	logic [trdt_pkg::CharW-1:0]       prefix_c;
	logic [trdt_pkg::CharW-1:0]       hund_c;
	logic [trdt_pkg::CharW-1:0]       tens_c;
	logic                             s1_adv;

	// handshake: the input stage moves on when the result stage is free
	assign s1_adv   = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !s1_adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			raw_s1  <= raw_reading;
			mins_s1 <= minutes_left;
			secs_s1 <= seconds_left;
		end
	end

	// sign detect, magnitude and whole degrees
	assign neg   = (raw_s1[15:8] & trdt_pkg::SIGN_MASK) == trdt_pkg::SIGN_MASK;
	assign mag   = neg ? (~raw_s1 + 16'd1) : raw_s1;
	assign whole = mag[10:4];

	// decimal digits: hundreds is at most one, the rest splits by ten
	assign hund_on    = whole >= trdt_pkg::HUNDRED;
	assign below_hund = hund_on ? (whole - trdt_pkg::HUNDRED) : whole;
	assign deg_dig    = trdt_pkg::div10(below_hund);
	assign min_dig    = trdt_pkg::div10(mins_s1);
	assign sec_dig    = trdt_pkg::div10(secs_s1);

	// blanking and sign placement
	always_comb begin
		prefix_c = trdt_pkg::CH_COLON;
		hund_c   = hund_on ? trdt_pkg::to_char(4'd1) : trdt_pkg::CH_SPACE;
		tens_c   = (!hund_on && deg_dig.quo == 4'd0) ? trdt_pkg::CH_SPACE
		                                             : trdt_pkg::to_char(deg_dig.quo);
		if (neg) begin
			priority if (tens_c == trdt_pkg::CH_SPACE) begin
				tens_c = trdt_pkg::CH_MINUS;
			end else if (!hund_on) begin
				hund_c = trdt_pkg::CH_MINUS;
			end else begin
				prefix_c = trdt_pkg::CH_MINUS;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && s1_adv) begin
			whole_s2  <= whole;
			neg_s2    <= neg;
			prefix_s2 <= prefix_c;
			hund_s2   <= hund_c;
			tens_s2   <= tens_c;
			ones_s2   <= trdt_pkg::to_char(deg_dig.rem);
			tenths_s2 <= trdt_pkg::to_char(trdt_pkg::tenths_digit(mag[3:0]));
			mt_s2     <= trdt_pkg::to_char(min_dig.quo);
			mo_s2     <= trdt_pkg::to_char(min_dig.rem);
			st_s2     <= trdt_pkg::to_char(sec_dig.quo);
			so_s2     <= trdt_pkg::to_char(sec_dig.rem);
		end
	end

	// outputs
	assign out_valid        = valid_s2;
	assign whole_degrees    = whole_s2;
	assign is_negative      = neg_s2;
	assign prefix_char      = prefix_s2;
	assign hundreds_char    = hund_s2;
	assign tens_char        = tens_s2;
	assign ones_char        = ones_s2;
	assign tenths_char      = tenths_s2;
	assign minute_tens_char = mt_s2;
	assign minute_ones_char = mo_s2;
	assign second_tens_char = st_s2;
	assign second_ones_char = so_s2;

endmodule

`default_nettype wire

/* hw/rtl/trdt_check.sv */
// port checker for the temperature text block, with its bind
`timescale 1ns / 1ps
`default_nettype none

module trdt_check (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_stall,
	input wire logic                              out_valid,
	input wire logic                              out_stall,
	input wire logic [trdt_pkg::WholeW-1:0]       whole_degrees,
	input wire logic                              is_negative,
	input wire logic [trdt_pkg::CharW-1:0]        prefix_char,
	input wire logic [trdt_pkg::CharW-1:0]        hundreds_char,
	input wire logic [trdt_pkg::CharW-1:0]        tens_char,
	input wire logic [trdt_pkg::CharW-1:0]        ones_char
);

	// a stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(whole_degrees)
			&& $stable(prefix_char) && $stable(tens_char) && $stable(ones_char))
		else $error("stalled result item changed");

	// a positive item never shows a minus sign
	a_pos_colon: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_negative |-> prefix_char == trdt_pkg::CH_COLON
			&& hundreds_char != trdt_pkg::CH_MINUS && tens_char != trdt_pkg::CH_MINUS)
		else $error("minus sign on a positive item");

	// a negative item shows exactly one minus sign
	a_neg_one_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_negative |-> $onehot({prefix_char == trdt_pkg::CH_MINUS,
			hundreds_char == trdt_pkg::CH_MINUS, tens_char == trdt_pkg::CH_MINUS}))
		else $error("negative item without exactly one minus sign");

	// below a hundred degrees the prefix keeps its colon
	a_small_colon: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && whole_degrees < trdt_pkg::HUNDRED |-> prefix_char == trdt_pkg::CH_COLON)
		else $error("sign in prefix with a blank digit free");

	// an empty block with a free output never stalls its input
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while output stage empty");

endmodule

bind temperature_reading_to_decimal_text trdt_check u_trdt_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.whole_degrees (whole_degrees),
	.is_negative   (is_negative),
	.prefix_char   (prefix_char),
	.hundreds_char (hundreds_char),
	.tens_char     (tens_char),
	.ones_char     (ones_char)
);

`default_nettype wire

/* bench/temperature_reading_to_decimal_text_tb.sv */
// self-checking bench for the temperature reading to decimal text converter
`timescale 1ns / 1ps

module temperature_reading_to_decimal_text_tb;

	localparam int RUN_LIMIT    = 400000;
	localparam int RANDOM_ITEMS = 1900;

	// tenths digit for each sixteenth, entry 0 in the lowest nibble
	localparam logic [63:0] TENTHS_LUT = 64'h9988_7665_4433_2110;

	typedef struct {
		logic [trdt_pkg::RawW-1:0]  raw;
		logic [trdt_pkg::TimeW-1:0] mins;
		logic [trdt_pkg::TimeW-1:0] secs;
		bit                         drain_first;
	} reading_item_t;

	typedef struct packed {
		logic [trdt_pkg::WholeW-1:0] whole_degrees;
		logic                        is_negative;
		logic [trdt_pkg::CharW-1:0]  prefix_char;
		logic [trdt_pkg::CharW-1:0]  hundreds_char;
		logic [trdt_pkg::CharW-1:0]  tens_char;
		logic [trdt_pkg::CharW-1:0]  ones_char;
		logic [trdt_pkg::CharW-1:0]  tenths_char;
		logic [trdt_pkg::CharW-1:0]  minute_tens_char;
		logic [trdt_pkg::CharW-1:0]  minute_ones_char;
		logic [trdt_pkg::CharW-1:0]  second_tens_char;
		logic [trdt_pkg::CharW-1:0]  second_ones_char;
	} display_text_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [trdt_pkg::RawW-1:0] raw_reading = '0;
	logic [trdt_pkg::TimeW-1:0] minutes_left = '0;
	logic [trdt_pkg::TimeW-1:0] seconds_left = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [trdt_pkg::WholeW-1:0] whole_degrees;
	logic is_negative;
	logic [trdt_pkg::CharW-1:0] prefix_char;
	logic [trdt_pkg::CharW-1:0] hundreds_char;
	logic [trdt_pkg::CharW-1:0] tens_char;
	logic [trdt_pkg::CharW-1:0] ones_char;
	logic [trdt_pkg::CharW-1:0] tenths_char;
	logic [trdt_pkg::CharW-1:0] minute_tens_char;
	logic [trdt_pkg::CharW-1:0] minute_ones_char;
	logic [trdt_pkg::CharW-1:0] second_tens_char;
	logic [trdt_pkg::CharW-1:0] second_ones_char;

	reading_item_t pending_readings[$];
	display_text_t text_expected[$];

	int cycle_count = 0;
	int mismatches = 0;
	int readings_taken = 0;
	int readings_shown = 0;
	int results_taken = 0;
	int results_seen = 0;
	int send_gap = 0;
	int recv_hold = 0;
	bit send_burst = 1'b0;
	bit recv_burst = 1'b0;

	temperature_reading_to_decimal_text DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.raw_reading      (raw_reading),
		.minutes_left     (minutes_left),
		.seconds_left     (seconds_left),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.whole_degrees    (whole_degrees),
		.is_negative      (is_negative),
		.prefix_char      (prefix_char),
		.hundreds_char    (hundreds_char),
		.tens_char        (tens_char),
		.ones_char        (ones_char),
		.tenths_char      (tenths_char),
		.minute_tens_char (minute_tens_char),
		.minute_ones_char (minute_ones_char),
		.second_tens_char (second_tens_char),
		.second_ones_char (second_ones_char)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [trdt_pkg::CharW-1:0] ascii_digit(input int unsigned d);
		return trdt_pkg::CharW'(trdt_pkg::CH_ZERO + d);
	endfunction

	// expected display text for one reading and countdown time
	function automatic display_text_t render_display(input logic [trdt_pkg::RawW-1:0] raw,
			input logic [trdt_pkg::TimeW-1:0] mins, input logic [trdt_pkg::TimeW-1:0] secs);
		display_text_t r;
		logic [trdt_pkg::RawW-1:0] mag;
		int unsigned whole;
		int unsigned h;
		int unsigned t;
		int unsigned o;
		r.is_negative = (raw[trdt_pkg::RawW-1:trdt_pkg::RawW-5] == 5'b11111);
		mag = r.is_negative ? (~raw + 16'd1) : raw;
		whole = 32'(mag[10:4]);
		h = whole / 100;
		t = (whole % 100) / 10;
		o = whole % 10;
		r.whole_degrees = trdt_pkg::WholeW'(whole);
		r.prefix_char = trdt_pkg::CH_COLON;
		r.hundreds_char = (h == 0) ? trdt_pkg::CH_SPACE : ascii_digit(h);
		r.tens_char = (h == 0 && t == 0) ? trdt_pkg::CH_SPACE : ascii_digit(t);
		// sign takes the blank place nearest the ones digit, else the prefix colon
		if (r.is_negative) begin
			if (r.tens_char == trdt_pkg::CH_SPACE) begin
				r.tens_char = trdt_pkg::CH_MINUS;
			end else if (r.hundreds_char == trdt_pkg::CH_SPACE) begin
				r.hundreds_char = trdt_pkg::CH_MINUS;
			end else begin
				r.prefix_char = trdt_pkg::CH_MINUS;
			end
		end
		r.ones_char = ascii_digit(o);
		r.tenths_char = ascii_digit(32'(TENTHS_LUT[{mag[3:0], 2'b00} +: 4]));
		r.minute_tens_char = ascii_digit(mins / 10);
		r.minute_ones_char = ascii_digit(mins % 10);
		r.second_tens_char = ascii_digit(secs / 10);
		r.second_ones_char = ascii_digit(secs % 10);
		return r;
	endfunction

	task automatic check_field(input string what, input logic [6:0] want,
			input logic [6:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			mismatches++;
		end
	endtask

	task automatic queue_reading(input logic [trdt_pkg::RawW-1:0] raw, input int mins,
			input int secs, input bit drain_first);
		reading_item_t it;
		it.raw = raw;
		it.mins = trdt_pkg::TimeW'(mins);
		it.secs = trdt_pkg::TimeW'(secs);
		it.drain_first = drain_first;
		pending_readings.push_back(it);
	endtask

	// reading drawn from a mix of classes so that negatives and digit edges are common
	function automatic logic [trdt_pkg::RawW-1:0] pick_raw();
		logic [trdt_pkg::RawW-1:0] v;
		logic [6:0] whole;
		logic [3:0] frac;
		case ($urandom_range(0, 3))
			0: v = trdt_pkg::RawW'($urandom);
			1: v = {5'b11111, 11'($urandom)};
			2: v = {5'b00000, 11'($urandom)};
			default: begin
				case ($urandom_range(0, 6))
					0: whole = 7'd0;
					1: whole = 7'd9;
					2: whole = 7'd10;
					3: whole = 7'd99;
					4: whole = 7'd100;
					5: whole = 7'd127;
					default: whole = 7'($urandom);
				endcase
				frac = 4'($urandom);
				v = {5'b00000, whole, frac};
				if ($urandom_range(0, 1) == 1) begin
					v = ~v + 16'd1;
				end
			end
		endcase
		return v;
	endfunction

	function automatic int pick_time();
		if ($urandom_range(0, 9) == 0) begin
			return $urandom_range(100, 127);
		end
		return $urandom_range(0, 99);
	endfunction

	// sender: presents queued items at the falling edge, holds them while stalled
	always @(negedge clk) begin : send_side
		reading_item_t it;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && readings_taken != readings_shown) begin
			// item still waiting for acceptance
		end else if (send_gap > 0) begin
			in_valid <= 1'b0;
			send_gap <= send_gap - 1;
		end else if (pending_readings.size() != 0 &&
				!(pending_readings[0].drain_first && text_expected.size() != 0)) begin
			it = pending_readings.pop_front();
			raw_reading <= it.raw;
			minutes_left <= it.mins;
			seconds_left <= it.secs;
			in_valid <= 1'b1;
			readings_shown <= readings_shown + 1;
			if ($urandom_range(0, 47) == 0) begin
				send_burst <= !send_burst;
			end
			send_gap <= send_burst ? 0 : $urandom_range(0, 15);
		end else begin
			in_valid <= 1'b0;
		end
	end

	// receiver: stalls a random number of cycles ahead of each result
	always @(negedge clk) begin : recv_side
		int wait_n;
		wait_n = recv_hold;
		if (results_taken != results_seen) begin
			if ($urandom_range(0, 47) == 0) begin
				recv_burst <= !recv_burst;
			end
			wait_n = recv_burst ? 0 : $urandom_range(0, 15);
		end
		results_seen <= results_taken;
		if (wait_n > 0) begin
			out_stall <= 1'b1;
			recv_hold <= wait_n - 1;
		end else begin
			out_stall <= 1'b0;
			recv_hold <= 0;
		end
	end

	// monitor: checks taken results, records expectations for taken items
	always @(posedge clk) begin : monitor
		display_text_t want;
		cycle_count <= cycle_count + 1;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_taken <= results_taken + 1;
				if (text_expected.size() == 0) begin
					$display("%0t ns: result with nothing expected, actual whole_degrees %0d",
						$time, whole_degrees);
					mismatches++;
				end else begin
					want = text_expected.pop_front();
					check_field("whole_degrees", want.whole_degrees, whole_degrees);
					check_field("is_negative", want.is_negative, is_negative);
					check_field("prefix_char", want.prefix_char, prefix_char);
					check_field("hundreds_char", want.hundreds_char, hundreds_char);
					check_field("tens_char", want.tens_char, tens_char);
					check_field("ones_char", want.ones_char, ones_char);
					check_field("tenths_char", want.tenths_char, tenths_char);
					check_field("minute_tens_char", want.minute_tens_char, minute_tens_char);
					check_field("minute_ones_char", want.minute_ones_char, minute_ones_char);
					check_field("second_tens_char", want.second_tens_char, second_tens_char);
					check_field("second_ones_char", want.second_ones_char, second_ones_char);
				end
			end
			if (in_valid && !in_stall) begin
				readings_taken <= readings_taken + 1;
				text_expected.push_back(render_display(raw_reading, minutes_left, seconds_left));
			end
		end
	end

	// run limit
	initial begin
		while (cycle_count < RUN_LIMIT) @(posedge clk);
		$display("temperature_reading_to_decimal_text verification failed");
		$finish;
	end

	// stimulus and end of run
	initial begin
		// zero, extremes of range and of every field
		queue_reading(16'h0000, 0, 0, 1'b0);
		queue_reading(16'hFFFF, 99, 99, 1'b0);
		queue_reading(16'h07FF, 127, 127, 1'b0);
		// negative zero pattern and times beyond 99
		queue_reading(16'hF800, 100, 0, 1'b0);
		queue_reading(16'hF801, 0, 100, 1'b0);
		// hundreds shown, sign falls back to the prefix
		queue_reading(16'h0640, 12, 34, 1'b0);
		queue_reading(16'hF9C0, 59, 59, 1'b0);
		queue_reading(16'h07F0, 64, 63, 1'b0);
		queue_reading(16'hF810, 63, 64, 1'b0);
		// sign in the hundreds place, after a full drain
		queue_reading(16'hFF60, 9, 10, 1'b1);
		// sign in the tens place
		queue_reading(16'hFFF0, 10, 9, 1'b0);
		queue_reading(16'hFFF8, 1, 1, 1'b0);
		// top bits not all set, so not negative
		queue_reading(16'h0800, 45, 54, 1'b0);
		queue_reading(16'hF000, 31, 96, 1'b0);
		queue_reading(16'h7FFF, 96, 31, 1'b0);
		queue_reading(16'h8000, 2, 7, 1'b0);
		// ninety-nine degrees each sign, then mixed bit patterns
		queue_reading(16'h0630, 0, 99, 1'b0);
		queue_reading(16'hF9D0, 99, 0, 1'b0);
		queue_reading(16'h00A5, 50, 5, 1'b0);
		queue_reading(16'h5555, 85, 42, 1'b0);
		queue_reading(16'hAAAA, 42, 85, 1'b0);
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			queue_reading(pick_raw(), pick_time(), pick_time(),
				(i == RANDOM_ITEMS / 2) || ($urandom_range(0, 149) == 0));
		end

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		while (!(pending_readings.size() == 0 && readings_taken == readings_shown &&
				text_expected.size() == 0)) @(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0 && text_expected.size() == 0) begin
			$display("temperature_reading_to_decimal_text verification clean");
		end else begin
			$display("temperature_reading_to_decimal_text verification failed");
		end
		$finish;
	end

endmodule
